FILE: design/iee_pkg.sv
`default_nettype none
package iee_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DATA_W);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      OP_PLUS  = 2'd0,
      OP_MINUS = 2'd1,
      OP_TIMES = 2'd2,
      OP_DIV   = 2'd3
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic apply;
      logic div_step;
      logic div_end;
      logic fin;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_break;
      logic last;
      logic div_go;
      logic div_last;
      logic rsp_free;
   } sts_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_op_char(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
   endfunction

   function automatic op_type to_op(input logic [7:0] c);
      op_type o;
      case (c)
         CH_MINUS: o = OP_MINUS;
         CH_STAR:  o = OP_TIMES;
         CH_SLASH: o = OP_DIV;
         default:  o = OP_PLUS;
      endcase
      return o;
   endfunction

endpackage
`default_nettype wire

FILE: design/iee_ctrl.sv
`default_nettype none
module iee_ctrl
   import iee_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_APPLY  = 5'b00010,
      S_DIV    = 5'b00100,
      S_DIVEND = 5'b01000,
      S_FIN    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && sts.in_break) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            if (sts.div_go) begin
               state_in = S_DIV;
            end else if (sts.last) begin
               state_in = S_FIN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DIVEND;
            end
         end
         S_DIVEND: begin
            cmd.div_end = 1'b1;
            state_in    = sts.last ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (sts.rsp_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/iee_dp.sv
`default_nettype none
module iee_dp
   import iee_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [7:0]               req_char_code,
   input  wire logic                     req_is_last,
   input  wire cmd_type                  cmd,
   output sts_type                       sts,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_value,
   output logic                          rsp_div_zero
);

   logic [DATA_W-1:0] num_ff, num_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [DATA_W-1:0] term_ff, term_in;
   logic              err_ff, err_in;
   logic              last_ff, last_in;
   logic              isop_ff, isop_in;
   op_type            newop_ff, newop_in;

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_dz_ff, rsp_dz_in;

   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   diff;
   logic              nt, nn;

   assign rem_sh = {rem_ff, quo_ff[DATA_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign nt     = term_ff[DATA_W-1];
   assign nn     = num_ff[DATA_W-1];

   always_comb begin
      num_in       = num_ff;
      op_in        = op_ff;
      sum_in       = sum_ff;
      term_in      = term_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      isop_in      = isop_ff;
      newop_in     = newop_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_value_in = rsp_value_ff;
      rsp_dz_in    = rsp_dz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         last_in  = req_is_last;
         isop_in  = is_op_char(req_char_code);
         newop_in = to_op(req_char_code);
         if (is_digit(req_char_code)) begin
            num_in = (num_ff << 3) + (num_ff << 1)
                   + {{(DATA_W-8){1'b0}}, req_char_code - CH_ZERO};
         end
      end

      if (cmd.apply) begin
         case (op_ff)
            OP_PLUS: begin
               sum_in  = sum_ff + term_ff;
               term_in = num_ff;
            end
            OP_MINUS: begin
               sum_in  = sum_ff + term_ff;
               term_in = '0 - num_ff;
            end
            OP_TIMES: begin
               term_in = term_ff * num_ff;
            end
            OP_DIV: begin
               if (num_ff == '0) begin
                  term_in = '0;
                  err_in  = 1'b1;
               end else begin
                  rem_in = '0;
                  quo_in = nt ? ('0 - term_ff) : term_ff;
                  dvs_in = nn ? ('0 - num_ff) : num_ff;
                  neg_in = nt ^ nn;
                  cnt_in = '0;
               end
            end
            default: begin
               term_in = term_ff;
            end
         endcase
         num_in = '0;
         if (isop_ff) begin
            op_in = newop_ff;
         end
      end

      if (cmd.div_step) begin
         cnt_in = cnt_ff + 1'b1;
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
      end

      if (cmd.div_end) begin
         term_in = neg_ff ? ('0 - quo_ff) : quo_ff;
      end

      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = sum_ff + term_ff;
         rsp_dz_in    = err_ff;
         num_in       = '0;
         op_in        = OP_PLUS;
         sum_in       = '0;
         term_in      = '0;
         err_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= '0;
         op_ff        <= OP_PLUS;
         sum_ff       <= '0;
         term_ff      <= '0;
         err_ff       <= 1'b0;
         last_ff      <= 1'b0;
         isop_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_ff       <= num_in;
         op_ff        <= op_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         err_ff       <= err_in;
         last_ff      <= last_in;
         isop_ff      <= isop_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      newop_ff     <= newop_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvs_ff       <= dvs_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   always_comb begin
      sts.in_break = is_op_char(req_char_code) || req_is_last;
      sts.last     = last_ff;
      sts.div_go   = (op_ff == OP_DIV) && (num_ff != '0);
      sts.div_last = (cnt_ff == CNT_W'(DATA_W - 1));
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_div_zero = rsp_dz_ff;

endmodule
`default_nettype wire

FILE: design/infix_expression_evaluator_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_char_code[7:0], req_is_last
// rsp       out        rsp_valid/rsp_ready  rsp_value[31:0] signed, rsp_div_zero
//
// Digit, space or other byte: taken in S_IDLE, ready stays high. + - * / or a
// final byte goes on to S_APPLY; a final byte then loads the result in S_FIN.
// A pending divide by a nonzero number runs the bit-serial divider:
// 32 iterations in S_DIV, then S_DIVEND writes the quotient term.
// reset is synchronous, active high; all evaluation state clears.
// A result held by rsp_ready low stalls only the next final byte.
`default_nettype none
module infix_expression_evaluator_unit
   import iee_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_char_code,
   input  wire logic                req_is_last,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic                     rsp_div_zero
);

   cmd_type cmd;
   sts_type sts;

   iee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iee_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_div_zero  (rsp_div_zero)
   );

endmodule
`default_nettype wire

FILE: design/iee_checker.sv
`default_nettype none
module iee_checker
   import iee_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [7:0]        req_char_code,
   input wire logic              req_is_last,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DATA_W-1:0] rsp_value,
   input wire logic              rsp_div_zero
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_div_zero))
      else $error("rsp transaction changed while stalled");

   // final byte always takes the evaluation path
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("ready right after final byte");

   // operator byte always takes the evaluation path
   a_op_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_char_code == CH_PLUS || req_char_code == CH_MINUS ||
      req_char_code == CH_STAR || req_char_code == CH_SLASH) |=> !req_ready)
      else $error("ready right after operator byte");

   // non-final digit bytes stream one per cycle
   a_digit_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_is_last &&
      req_char_code >= CH_ZERO && req_char_code <= CH_NINE |=> req_ready)
      else $error("digit byte stalled input");

   // a new result only appears while input is blocked
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without evaluation");

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_char_code (req_char_code),
   .req_is_last   (req_is_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value     (rsp_value),
   .rsp_div_zero  (rsp_div_zero)
);
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
module tb_top
   import iee_pkg::*;
;

   localparam int GAP_MAX      = 13;
   localparam int LONG_HOLD    = 600;
   localparam int WDOG_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_BYTES  = 175;
   localparam int NUM_PHASES   = 8;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } req_byte_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     div_zero;
   } sum_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_char_code = 8'h00;
   logic                     req_is_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic                     rsp_div_zero;

   infix_expression_evaluator_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_div_zero  (rsp_div_zero)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // evaluation state of the expected-value predictor
   logic [DATA_W-1:0] num_acc  = '0;
   op_type            pend_op  = OP_PLUS;
   logic [DATA_W-1:0] sum_fin  = '0;
   logic [DATA_W-1:0] term_cur = '0;
   logic              err_seen = 1'b0;

   req_byte_type   pend_bytes[$];
   sum_result_type expected_sums[$];
   sum_result_type want;
   req_byte_type   cur_byte;

   int tx_gap_max = 0;
   int rx_gap_max = 0;
   int tx_wait = 0;
   int rx_wait = 0;
   int rx_hold = 0;
   bit hold_request = 1'b0;
   int idle_cycles = 0;
   int err_count = 0;
   int bytes_sent = 0;
   int sums_checked = 0;
   int dz_checked = 0;
   int bytes_queued = 0;

   function automatic void evaluate_byte(input logic [7:0] code, input logic last);
      logic              is_op;
      op_type            new_op;
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
      logic [DATA_W-1:0] quo;
      is_op = 1'b0;
      new_op = OP_PLUS;
      if (code >= CH_ZERO && code <= CH_NINE) begin
         num_acc = num_acc * 10 + DATA_W'(code - CH_ZERO);
      end
      case (code)
         CH_PLUS: begin
            is_op = 1'b1;
            new_op = OP_PLUS;
         end
         CH_MINUS: begin
            is_op = 1'b1;
            new_op = OP_MINUS;
         end
         CH_STAR: begin
            is_op = 1'b1;
            new_op = OP_TIMES;
         end
         CH_SLASH: begin
            is_op = 1'b1;
            new_op = OP_DIV;
         end
         default: ;
      endcase
      if (is_op || last) begin
         case (pend_op)
            OP_PLUS: begin
               sum_fin = sum_fin + term_cur;
               term_cur = num_acc;
            end
            OP_MINUS: begin
               sum_fin = sum_fin + term_cur;
               term_cur = -num_acc;
            end
            OP_TIMES: begin
               term_cur = term_cur * num_acc;
            end
            default: begin
               if (num_acc == '0) begin
                  term_cur = '0;
                  err_seen = 1'b1;
               end else begin
                  mag_a = term_cur[DATA_W-1] ? -term_cur : term_cur;
                  mag_b = num_acc[DATA_W-1] ? -num_acc : num_acc;
                  quo = mag_a / mag_b;
                  term_cur = (term_cur[DATA_W-1] ^ num_acc[DATA_W-1]) ? -quo : quo;
               end
            end
         endcase
         num_acc = '0;
         if (is_op) pend_op = new_op;
      end
      if (last) begin
         expected_sums.push_back('{value: $signed(sum_fin + term_cur), div_zero: err_seen});
         num_acc = '0;
         pend_op = OP_PLUS;
         sum_fin = '0;
         term_cur = '0;
         err_seen = 1'b0;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            evaluate_byte(req_char_code, req_is_last);
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_valid <= 1'b0;
            end else if (pend_bytes.size() > 0) begin
               cur_byte = pend_bytes.pop_front();
               req_valid <= 1'b1;
               req_char_code <= cur_byte.code;
               req_is_last <= cur_byte.last;
               tx_wait = $urandom_range(0, tx_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait = 0;
         rx_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               $error("unexpected transaction: value %0d div_zero %0b",
                      rsp_value, rsp_div_zero);
               err_count++;
            end else begin
               want = expected_sums.pop_front();
               sums_checked++;
               if (want.div_zero) dz_checked++;
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  err_count++;
               end
               if (rsp_div_zero !== want.div_zero) begin
                  $error("div_zero: expected %0b, actual %0b", want.div_zero, rsp_div_zero);
                  err_count++;
               end
            end
            rx_wait = $urandom_range(0, rx_gap_max);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            rx_hold = LONG_HOLD;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic logic [7:0] pick_op_char();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0:       c = CH_PLUS;
         1:       c = CH_MINUS;
         2:       c = CH_STAR;
         default: c = CH_SLASH;
      endcase
      return c;
   endfunction

   task automatic queue_text(input string s, input logic mark_last);
      for (int i = 0; i < s.len(); i++) begin
         pend_bytes.push_back('{code: s[i], last: mark_last && (i == s.len() - 1)});
      end
   endtask

   task automatic queue_expression();
      logic [7:0] body[$];
      int         n_terms;
      int         n_digits;
      int         style;
      int         ending;
      n_terms = $urandom_range(1, 6);
      for (int t = 0; t < n_terms; t++) begin
         if (t > 0) begin
            body.push_back(pick_op_char());
            if ($urandom_range(0, 9) == 0) body.push_back(pick_op_char());
         end
         if ($urandom_range(0, 3) == 0) body.push_back(" ");
         if ($urandom_range(0, 19) != 0) begin
            style = $urandom_range(0, 9);
            if (style < 7) n_digits = $urandom_range(1, 2);
            else if (style < 9) n_digits = $urandom_range(3, 6);
            else n_digits = $urandom_range(9, 12);
            for (int d = 0; d < n_digits; d++) begin
               body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
               if ($urandom_range(0, 39) == 0) body.push_back(8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 5) == 0) body.push_back(" ");
         if ($urandom_range(0, 15) == 0) body.push_back(8'($urandom_range(0, 255)));
      end
      ending = $urandom_range(0, 9);
      if (body.size() == 0 || ending >= 6) begin
         if (ending < 8) body.push_back(($urandom_range(0, 1) == 0) ? 8'h20
                                        : 8'($urandom_range(0, 255)));
         else body.push_back(pick_op_char());
      end
      foreach (body[i]) begin
         pend_bytes.push_back('{code: body[i], last: (i == body.size() - 1)});
      end
      bytes_queued += body.size();
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pend_bytes.size() != 0 || req_valid || expected_sums.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // most negative term divided by a wrapped -1, closed by a NUL final byte
      queue_text("-2147483648/4294967295", 1'b0);
      pend_bytes.push_back('{code: 8'h00, last: 1'b1});
      // empty expression
      pend_bytes.push_back('{code: 8'hFF, last: 1'b1});
      // missing operands, divide by zero, trailing operator dropped
      queue_text(" +/0*", 1'b1);
      queue_text("12*3-7/2", 1'b1);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         tx_gap_max = (ph % 2 == 1) ? GAP_MAX : 0;
         rx_gap_max = (ph % 4 >= 2) ? GAP_MAX : 0;
         if (ph == 0) hold_request = 1'b1;
         bytes_queued = 0;
         while (bytes_queued < PHASE_BYTES) queue_expression();
         wait_drained();
      end

      $display("Checked %0d expression results over %0d bytes, %0d with a zero divisor.",
               sums_checked, bytes_sent, dz_checked);
      $display("Sender and receiver gaps 0..%0d, plus a %0d-cycle result hold.",
               GAP_MAX, LONG_HOLD);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
